// ===== rtl/core/skhm_pkg.sv =====
// ----------------------------------------------------------------------------
// skhm_pkg
// Types and constants shared by the string key hash map.
// ----------------------------------------------------------------------------
package skhm_pkg;

	localparam logic [63:0] HASH_INIT = 64'h100;
	localparam logic [63:0] HASH_MUL  = 64'd1111111111111111111;
	localparam int          HASH_STEPS = 4;   // 16-bit multiplier chunks per byte

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_TOO_LONG  = 3'd5
	} status_t;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_SET = 1'b1;

	typedef struct packed {
		logic [7:0]  key_byte;
		logic        func;
		logic [31:0] value;
	} req_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] found_value;
	} rsp_item_t;

	typedef struct packed {
		logic       start;
		logic       clear;
		logic [7:0] data;
	} hash_cmd_t;

endpackage

// ===== rtl/core/skhm_ram.sv =====
// ----------------------------------------------------------------------------
// skhm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skhm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/skhm_hash.sv =====
// ----------------------------------------------------------------------------
// skhm_hash
// Running xor-multiply hash, one 64x16 partial product per cycle.
// ----------------------------------------------------------------------------
module skhm_hash import skhm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hash_cmd_t   cmd,
	output logic        done,
	output logic [63:0] hash
);

	logic [63:0] h_q, xs_q, acc_q, prod;
	logic [1:0]  k_q;
	logic        busy_q, done_q;
	logic [15:0] chunk;

	assign chunk = HASH_MUL[{k_q, 4'b0000} +: 16];
	assign prod  = xs_q * {48'h0, chunk};
	assign done  = done_q;
	assign hash  = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= HASH_INIT;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
			xs_q   <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				acc_q <= acc_q + prod;
				xs_q  <= xs_q << 16;
				k_q   <= k_q + 2'd1;
				if (k_q == 2'(HASH_STEPS - 1)) begin
					h_q    <= acc_q + prod;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (cmd.start) begin
				xs_q   <= h_q ^ {56'h0, cmd.data};
				acc_q  <= '0;
				k_q    <= '0;
				busy_q <= 1'b1;
			end else if (cmd.clear) begin
				h_q <= HASH_INIT;
			end
		end
	end

endmodule

// ===== rtl/core/string_key_hash_map.sv =====
// ----------------------------------------------------------------------------
// string_key_hash_map
// String-keyed map over an open-addressing table with double hashing.
// ----------------------------------------------------------------------------
// Keys arrive one byte per item; a zero byte ends the key and carries the
// operation. A nonzero byte is accepted, runs four 16-bit steps of the
// shared hash multiplier and then picks up the new hash. The terminating
// item does the same, then a fold, then per probe a slot-used read and
// check plus a key read and compare per compared byte (up to key length plus
// one, from the single-port key store read), a final step if the probe
// visits every slot, then the answer (after a value read for a found get).
// An insert instead copies the key byte by byte before it answers. An
// over-long key answers straight after its hash. A result that is still
// stalled holds the block. After reset a clearing pass over every slot
// wipes the slot-used map, during which no item is accepted.
module string_key_hash_map import skhm_pkg::*; #(
	parameter int TABLE_EXP     = 10,
	parameter int MAX_KEY_BYTES = 32,
	parameter int VALUE_BITS    = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int SLOTS    = 1 << TABLE_EXP;
	localparam int KW       = $clog2(MAX_KEY_BYTES);
	localparam int CW       = TABLE_EXP + 1;
	localparam int FULL_LIM = (3 * SLOTS) / 4;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_FOLD, S_PROBE, S_USED_RD, S_USED_CHK,
		S_CMP_RD, S_CMP_CHK, S_DECIDE, S_VAL_RD, S_VAL_CHK, S_COPY_RD,
		S_COPY_WR, S_RESULT
	} state_t;

	state_t               state_q;
	logic [KW-1:0]        len_q, j_q;
	logic                 ovf_q, func_q, hit_q, empty_q;
	logic [7:0]           byte_q;
	logic [31:0]          value_q, res_value_q;
	status_t              res_status_q;
	logic [TABLE_EXP-1:0] idx_q, step_q, clr_q;
	logic [CW-1:0]        n_q, cnt_q;
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q;

	hash_cmd_t   hcmd;
	logic        hdone;
	logic [63:0] hval, hfold;
	logic        load, insert;

	logic                 kb_we, ks_we, vs_we, us_we;
	logic [7:0]           kb_rd, ks_rd, ks_wdata;
	logic [VALUE_BITS-1:0] vs_rd, vs_wdata;
	logic                 us_rd;
	logic [TABLE_EXP-1:0] us_waddr;
	logic [63:0]          v64, rd64;

	assign load   = (state_q == S_RESULT) && (!rsp_valid_q || !rsp_stall);
	assign insert = (state_q == S_COPY_RD) && (j_q == len_q);
	assign hfold  = hval ^ (hval >> 32);

	assign hcmd.start = (state_q == S_IDLE) && req_valid;
	assign hcmd.clear = load;
	assign hcmd.data  = req.key_byte;

	assign kb_we = (state_q == S_IDLE) && req_valid && (req.key_byte != 8'h00)
		&& (len_q != KW'(MAX_KEY_BYTES - 1));
	assign ks_we    = insert || (state_q == S_COPY_WR);
	assign ks_wdata = (state_q == S_COPY_WR) ? kb_rd : 8'h00;
	assign vs_we    = insert || ((state_q == S_DECIDE) && (func_q == FUNC_SET) && hit_q);
	assign us_we    = (state_q == S_CLEAR) || insert;
	assign us_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign v64      = {32'h0, value_q};
	assign vs_wdata = v64[VALUE_BITS-1:0];
	assign rd64     = 64'(vs_rd);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	skhm_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hcmd),
		.done   (hdone),
		.hash   (hval)
	);

	skhm_ram #(.WIDTH(8), .DEPTH(1 << KW)) u_key_buf (
		.clk   (clk),
		.we    (kb_we),
		.waddr (len_q),
		.wdata (req.key_byte),
		.raddr (j_q),
		.rdata (kb_rd)
	);

	skhm_ram #(.WIDTH(8), .DEPTH(SLOTS << KW)) u_key_store (
		.clk   (clk),
		.we    (ks_we),
		.waddr ({idx_q, j_q}),
		.wdata (ks_wdata),
		.raddr ({idx_q, j_q}),
		.rdata (ks_rd)
	);

	skhm_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_value_store (
		.clk   (clk),
		.we    (vs_we),
		.waddr (idx_q),
		.wdata (vs_wdata),
		.raddr (idx_q),
		.rdata (vs_rd)
	);

	skhm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_slot_used (
		.clk   (clk),
		.we    (us_we),
		.waddr (us_waddr),
		.wdata (state_q != S_CLEAR),
		.raddr (idx_q),
		.rdata (us_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			len_q        <= '0;
			ovf_q        <= 1'b0;
			cnt_q        <= '0;
			rsp_valid_q  <= 1'b0;
			j_q          <= '0;
			n_q          <= '0;
			hit_q        <= 1'b0;
			empty_q      <= 1'b0;
			res_status_q <= ST_NOT_FOUND;
		end else begin
			if (rsp_valid_q && !rsp_stall && !load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						byte_q  <= req.key_byte;
						func_q  <= req.func;
						value_q <= req.value;
						if (req.key_byte != 8'h00) begin
							if (len_q == KW'(MAX_KEY_BYTES - 1)) begin
								ovf_q <= 1'b1;
							end else begin
								len_q <= len_q + 1'b1;
							end
						end
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hdone) begin
						if (byte_q != 8'h00) begin
							state_q <= S_IDLE;
						end else if (ovf_q) begin
							res_status_q <= ST_TOO_LONG;
							res_value_q  <= '0;
							state_q      <= S_RESULT;
						end else begin
							state_q <= S_FOLD;
						end
					end
				end
				S_FOLD: begin
					idx_q   <= hfold[TABLE_EXP-1:0];
					step_q  <= hfold[63 -: TABLE_EXP] | TABLE_EXP'(1);
					n_q     <= '0;
					hit_q   <= 1'b0;
					empty_q <= 1'b0;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (n_q == CW'(SLOTS)) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q   <= idx_q + step_q;
						n_q     <= n_q + 1'b1;
						state_q <= S_USED_RD;
					end
				end
				S_USED_RD: state_q <= S_USED_CHK;
				S_USED_CHK: begin
					j_q <= '0;
					if (!us_rd) begin
						empty_q <= 1'b1;
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_CMP_RD;
					end
				end
				S_CMP_RD: state_q <= S_CMP_CHK;
				S_CMP_CHK: begin
					// stored key must end in zero right after the buffered bytes
					if (ks_rd != ((j_q == len_q) ? 8'h00 : kb_rd)) begin
						state_q <= S_PROBE;
					end else if (j_q == len_q) begin
						hit_q   <= 1'b1;
						state_q <= S_DECIDE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_CMP_RD;
					end
				end
				S_DECIDE: begin
					res_value_q <= '0;
					j_q         <= '0;
					if (func_q == FUNC_GET) begin
						if (hit_q) begin
							state_q <= S_VAL_RD;
						end else begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_RESULT;
						end
					end else if (hit_q) begin
						res_status_q <= ST_REPLACED;
						state_q      <= S_RESULT;
					end else if (!empty_q || (cnt_q >= CW'(FULL_LIM))) begin
						res_status_q <= ST_FULL;
						state_q      <= S_RESULT;
					end else begin
						state_q <= S_COPY_RD;
					end
				end
				S_VAL_RD: state_q <= S_VAL_CHK;
				S_VAL_CHK: begin
					res_status_q <= ST_FOUND;
					res_value_q  <= rd64[31:0];
					state_q      <= S_RESULT;
				end
				S_COPY_RD: begin
					if (insert) begin
						cnt_q        <= cnt_q + 1'b1;
						res_status_q <= ST_INSERTED;
						state_q      <= S_RESULT;
					end else begin
						state_q <= S_COPY_WR;
					end
				end
				S_COPY_WR: begin
					j_q     <= j_q + 1'b1;
					state_q <= S_COPY_RD;
				end
				S_RESULT: begin
					if (load) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.status      <= res_status_q;
						rsp_q.found_value <= res_value_q;
						len_q             <= '0;
						ovf_q             <= 1'b0;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FULL_LIM))
		else $error("entry count above load limit");

	a_value_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_FOUND) |-> rsp.found_value == 32'h0)
		else $error("found_value set without found status");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not bump entry count");

endmodule
